// File: design/lbp_pkg.sv
package lbp_pkg;

   // request operation codes
   localparam logic [2:0] MODE_TICK  = 3'd0;
   localparam logic [2:0] MODE_START = 3'd1;
   localparam logic [2:0] MODE_STOP  = 3'd2;
   localparam logic [2:0] MODE_SET   = 3'd3;
   localparam logic [2:0] MODE_WRITE = 3'd4;

   // control register indexes
   localparam logic [2:0] CSR_PWM_MODE      = 3'd0;
   localparam logic [2:0] CSR_ACTIVE_LOW    = 3'd1;
   localparam logic [2:0] CSR_MAX_LEVEL     = 3'd2;
   localparam logic [2:0] CSR_BLINK_LEVEL   = 3'd3;
   localparam logic [2:0] CSR_PATTERN_PAIRS = 3'd4;

   // reset values
   localparam logic [15:0] RESET_LEVEL    = 16'd255;
   localparam logic [2:0]  RESET_PAIRS    = 3'd1;
   localparam int          RESET_DURATION = 500;

   typedef struct packed {
      logic [2:0]  mode;
      logic [15:0] repeat_count;
      logic [31:0] value;
      logic [2:0]  entry_index;
   } req_type;

   typedef struct packed {
      logic [15:0] drive_level;
      logic        blinking;
      logic        finished;
   } rsp_type;

   typedef struct packed {
      logic        pwm_mode;
      logic        active_low;
      logic [15:0] max_level;
      logic [15:0] blink_level;
      logic [2:0]  pattern_pairs;
   } cfg_type;

endpackage

// File: design/lbp_pattern_mem.sv
module lbp_pattern_mem #(
   parameter int DEPTH = 8,
   parameter int WIDTH = 32
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr0,
   input  logic [$clog2(DEPTH)-1:0] rd_addr1,
   output logic [WIDTH-1:0]         rd_data0,
   output logic [WIDTH-1:0]         rd_data1,
   output logic                     entry0_nz
);

   localparam int AW = $clog2(DEPTH);
   localparam logic [WIDTH-1:0] INIT_DUR = WIDTH'(lbp_pkg::RESET_DURATION);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [DEPTH-1:0] valid_ff;
   logic [WIDTH-1:0] raw0_ff, raw1_ff;
   logic             ok0_ff, ok1_ff, low0_ff, low1_ff;
   logic             entry0_nz_ff;

   // storage array, no reset
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // per-entry written flags; unwritten entries 0 and 1 read as their reset duration, others as zero
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (wr_en) begin
         valid_ff[wr_addr] <= 1'b1;
      end
   end

   // entry 0 nonzero shadow, used on start and on wrap
   always_ff @(posedge clock) begin
      if (reset) begin
         entry0_nz_ff <= (INIT_DUR != '0);
      end else if (wr_en && (wr_addr == AW'(0))) begin
         entry0_nz_ff <= (wr_data != '0);
      end
   end

   // registered reads on both ports
   always_ff @(posedge clock) begin
      if (rd_en) begin
         raw0_ff <= mem[rd_addr0];
         raw1_ff <= mem[rd_addr1];
         ok0_ff  <= valid_ff[rd_addr0];
         ok1_ff  <= valid_ff[rd_addr1];
         low0_ff <= (32'(rd_addr0) < 2);
         low1_ff <= (32'(rd_addr1) < 2);
      end
   end

   assign rd_data0  = ok0_ff ? raw0_ff : (low0_ff ? INIT_DUR : '0);
   assign rd_data1  = ok1_ff ? raw1_ff : (low1_ff ? INIT_DUR : '0);
   assign entry0_nz = entry0_nz_ff;

endmodule

// File: design/lbp_seq_core.sv
module lbp_seq_core #(
   parameter int PATTERN_DEPTH = 8,
   parameter int DURATION_BITS = 32
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             fire_i,
   input  lbp_pkg::req_type                 item_i,
   input  lbp_pkg::cfg_type                 cfg_i,
   input  logic [DURATION_BITS-1:0]         cur_dur_i,
   input  logic [DURATION_BITS-1:0]         next_dur_i,
   input  logic                             entry0_nz_i,
   output logic [$clog2(PATTERN_DEPTH)-1:0] rd_addr0_o,
   output logic [$clog2(PATTERN_DEPTH)-1:0] rd_addr1_o,
   output lbp_pkg::rsp_type                 rsp_o
);

   localparam int AW   = $clog2(PATTERN_DEPTH);
   localparam int CW   = AW + 1;
   localparam int HALF = PATTERN_DEPTH / 2;
   localparam int DW   = DURATION_BITS;

   logic          active_ff, active_in;
   logic [AW-1:0] phase_ff, phase_in;
   logic [DW-1:0] elapsed_ff, elapsed_in;
   logic [15:0]   reps_done_ff, reps_done_in;
   logic [15:0]   reps_target_ff, reps_target_in;
   logic [15:0]   level_ff, level_in;
   logic          fin;

   logic [DW-1:0] el_inc;
   logic [CW-1:0] limit;
   logic [CW-1:0] p_plus1;
   logic [CW-1:0] a1_wide;
   logic          wrap;
   logic          next_nz;
   logic [15:0]   done_step;

   // clamp, then digital or pwm mapping, then polarity
   function automatic logic [15:0] drive_fn(input logic [31:0] lvl,
                                            input lbp_pkg::cfg_type c);
      logic [15:0] s;
      logic        b;
      s = (lvl > {16'd0, c.max_level}) ? c.max_level : lvl[15:0];
      b = (s != 16'd0);
      if (c.pwm_mode) begin
         drive_fn = c.active_low ? (c.max_level - s) : s;
      end else begin
         drive_fn = {15'd0, b ^ c.active_low};
      end
   endfunction

   // pair count clamped to 1..depth/2, as a phase limit
   always_comb begin
      if (cfg_i.pattern_pairs == 3'd0) begin
         limit = CW'(2);
      end else if (32'(cfg_i.pattern_pairs) > HALF) begin
         limit = CW'(2 * HALF);
      end else begin
         limit = CW'({cfg_i.pattern_pairs, 1'b0});
      end
   end

   assign el_inc    = (elapsed_ff == '1) ? elapsed_ff : elapsed_ff + DW'(1);
   assign p_plus1   = {1'b0, phase_ff} + CW'(1);
   assign wrap      = (p_plus1 >= limit);
   assign next_nz   = (next_dur_i != '0);
   assign done_step = reps_done_ff + 16'((wrap && reps_target_ff != 16'd0) ? 1 : 0);

   // sequencer next state
   always_comb begin
      active_in      = active_ff;
      phase_in       = phase_ff;
      elapsed_in     = elapsed_ff;
      reps_done_in   = reps_done_ff;
      reps_target_in = reps_target_ff;
      level_in       = level_ff;
      fin            = 1'b0;
      if (fire_i) begin
         unique case (item_i.mode)
            lbp_pkg::MODE_TICK: begin
               if (active_ff) begin
                  if (el_inc < cur_dur_i) begin
                     elapsed_in = el_inc;
                  end else begin
                     elapsed_in = '0;
                     if (!phase_ff[0]) begin
                        // end of an on phase
                        phase_in = p_plus1[AW-1:0];
                        if (next_nz) begin
                           level_in = drive_fn(32'd0, cfg_i);
                        end
                     end else begin
                        // end of an off phase
                        phase_in     = wrap ? '0 : p_plus1[AW-1:0];
                        reps_done_in = done_step;
                        if (reps_target_ff != 16'd0 && done_step >= reps_target_ff) begin
                           active_in = 1'b0;
                           level_in  = drive_fn(32'd0, cfg_i);
                           fin       = 1'b1;
                        end else if (wrap ? entry0_nz_i : next_nz) begin
                           level_in = drive_fn({16'd0, cfg_i.blink_level}, cfg_i);
                        end
                     end
                  end
               end
            end
            lbp_pkg::MODE_START: begin
               reps_target_in = item_i.repeat_count;
               level_in       = drive_fn(entry0_nz_i ? {16'd0, cfg_i.blink_level} : 32'd0,
                                         cfg_i);
               active_in      = 1'b1;
               reps_done_in   = 16'd0;
               phase_in       = '0;
               elapsed_in     = '0;
            end
            lbp_pkg::MODE_STOP: begin
               if (active_ff) begin
                  active_in = 1'b0;
                  level_in  = drive_fn(32'd0, cfg_i);
                  fin       = 1'b1;
               end
            end
            lbp_pkg::MODE_SET: begin
               if (!active_ff) begin
                  level_in = drive_fn(item_i.value, cfg_i);
               end
            end
            default: begin
               // pattern writes go straight to the store; other codes do nothing
            end
         endcase
      end
   end

   // state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff      <= 1'b0;
         phase_ff       <= '0;
         elapsed_ff     <= '0;
         reps_done_ff   <= 16'd0;
         reps_target_ff <= 16'd0;
         level_ff       <= 16'd0;
      end else begin
         active_ff      <= active_in;
         phase_ff       <= phase_in;
         elapsed_ff     <= elapsed_in;
         reps_done_ff   <= reps_done_in;
         reps_target_ff <= reps_target_in;
         level_ff       <= level_in;
      end
   end

   // store read addresses follow the phase the next item will see
   assign a1_wide    = {1'b0, phase_in} + CW'(1);
   assign rd_addr0_o = phase_in;
   assign rd_addr1_o = (a1_wide >= CW'(PATTERN_DEPTH)) ? '0 : a1_wide[AW-1:0];

   assign rsp_o = '{drive_level: level_in, blinking: active_in, finished: fin};

   a_fin_stops: assert property (@(posedge clock) disable iff (reset)
      (fire_i && rsp_o.finished) |=> !active_ff)
      else $error("finished reported but sequence still active");

   a_phase_range: assert property (@(posedge clock) disable iff (reset)
      32'(phase_ff) < PATTERN_DEPTH)
      else $error("phase index beyond pattern depth");

   a_start_clears: assert property (@(posedge clock) disable iff (reset)
      (fire_i && item_i.mode == lbp_pkg::MODE_START)
         |=> (active_ff && phase_ff == '0 && elapsed_ff == '0 && reps_done_ff == 16'd0))
      else $error("start did not restart the sequence");

endmodule

// File: design/led_blink_pattern_sequencer.sv
// Blink pattern sequencer: steps one output level through a table of on/off
// durations, one request per millisecond tick, with start, stop, direct level
// and table write requests. Every request gives exactly one response. One
// request can be taken each clock cycle while the response register is not
// stalled; a response passes through the registered read of the duration
// table and then the sequencer update into the output register. Entries 0
// and 1 that were never written read as their reset duration, others as zero,
// so no clearing pass runs after reset.
module led_blink_pattern_sequencer #(
   parameter int PATTERN_DEPTH = 8,
   parameter int DURATION_BITS = 32
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  lbp_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output lbp_pkg::rsp_type rsp_data,
   input  logic             csr_write_en,
   input  logic [2:0]       csr_index,
   input  logic [15:0]      csr_wdata
);

   localparam int AW = $clog2(PATTERN_DEPTH);

   lbp_pkg::cfg_type cfg_ff, cfg_in;
   lbp_pkg::req_type item_ff;
   lbp_pkg::rsp_type rsp_data_ff, core_rsp;
   logic             busy_ff, busy_in;
   logic             rsp_valid_ff, rsp_valid_in;
   logic             core_move, req_fire;
   logic             wr_en;
   logic [AW-1:0]    rd_addr0, rd_addr1;
   logic [DURATION_BITS-1:0] cur_dur, next_dur;
   logic             entry0_nz;

   // control register writes
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write_en) begin
         unique case (csr_index)
            lbp_pkg::CSR_PWM_MODE:      cfg_in.pwm_mode      = csr_wdata[0];
            lbp_pkg::CSR_ACTIVE_LOW:    cfg_in.active_low    = csr_wdata[0];
            lbp_pkg::CSR_MAX_LEVEL:     cfg_in.max_level     = csr_wdata;
            lbp_pkg::CSR_BLINK_LEVEL:   cfg_in.blink_level   = csr_wdata;
            lbp_pkg::CSR_PATTERN_PAIRS: cfg_in.pattern_pairs = csr_wdata[2:0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '{pwm_mode: 1'b0, active_low: 1'b0,
                     max_level: lbp_pkg::RESET_LEVEL,
                     blink_level: lbp_pkg::RESET_LEVEL,
                     pattern_pairs: lbp_pkg::RESET_PAIRS};
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // two-stage flow: table read stage, then sequencer into output register
   assign core_move    = busy_ff && (!rsp_valid_ff || !rsp_stall);
   assign req_stall    = busy_ff && !core_move;
   assign req_fire     = req_valid && !req_stall;
   assign busy_in      = req_fire || (busy_ff && !core_move);
   assign rsp_valid_in = core_move || (rsp_valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         busy_ff      <= busy_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (req_fire) begin
         item_ff <= req_data;
      end
      if (core_move) begin
         rsp_data_ff <= core_rsp;
      end
   end

   // table writes land at the request transfer
   assign wr_en = req_fire && (req_data.mode == lbp_pkg::MODE_WRITE)
                  && (32'(req_data.entry_index) < PATTERN_DEPTH);

   lbp_pattern_mem #(
      .DEPTH (PATTERN_DEPTH),
      .WIDTH (DURATION_BITS)
   ) u_mem (
      .clock     (clock),
      .reset     (reset),
      .wr_en     (wr_en),
      .wr_addr   (AW'(req_data.entry_index)),
      .wr_data   (DURATION_BITS'(req_data.value)),
      .rd_en     (req_fire),
      .rd_addr0  (rd_addr0),
      .rd_addr1  (rd_addr1),
      .rd_data0  (cur_dur),
      .rd_data1  (next_dur),
      .entry0_nz (entry0_nz)
   );

   lbp_seq_core #(
      .PATTERN_DEPTH (PATTERN_DEPTH),
      .DURATION_BITS (DURATION_BITS)
   ) u_core (
      .clock       (clock),
      .reset       (reset),
      .fire_i      (core_move),
      .item_i      (item_ff),
      .cfg_i       (cfg_ff),
      .cur_dur_i   (cur_dur),
      .next_dur_i  (next_dur),
      .entry0_nz_i (entry0_nz),
      .rd_addr0_o  (rd_addr0),
      .rd_addr1_o  (rd_addr1),
      .rsp_o       (core_rsp)
   );

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

// File: test/blink_checker.sv
`timescale 1ns / 1ps

module blink_checker (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   input  logic             req_stall,
   input  lbp_pkg::req_type req_data,
   input  logic             rsp_valid,
   input  logic             rsp_stall,
   input  lbp_pkg::rsp_type rsp_data,
   input  logic             csr_write_en,
   input  logic [2:0]       csr_index,
   input  logic [15:0]      csr_wdata,
   output int               fail_count,
   output int               states_due,
   output int               states_checked,
   output int               blinks_ended
);
   import lbp_pkg::*;

   localparam int          TABLE_DEPTH = 8;
   localparam logic [31:0] MS_CEILING  = 32'hFFFF_FFFF;
   localparam int          SHOWN_MAX   = 10;

   // private copy of the sequencer state and its registers
   cfg_type     cfg;
   logic [31:0] durations [TABLE_DEPTH];
   logic        running;
   int unsigned phase;
   logic [31:0] elapsed;
   logic [15:0] reps_done;
   logic [15:0] reps_target;
   logic [15:0] pin_level;
   rsp_type     pin_states_due [$];

   function automatic logic [31:0] duration_at(int unsigned i);
      return (i < TABLE_DEPTH) ? durations[i] : 32'd0;
   endfunction

   // pair count register saturates to half the table size, zero acts as one
   function automatic int unsigned pairs_in_use();
      int unsigned p;
      p = cfg.pattern_pairs;
      if (p < 1) p = 1;
      if (p > TABLE_DEPTH / 2) p = TABLE_DEPTH / 2;
      return p;
   endfunction

   // clamp, then either pwm level or 0/1, then optional inversion
   function automatic void drive_pin(logic [31:0] level);
      logic [31:0] clamped;
      logic        lit;
      clamped = (level > {16'd0, cfg.max_level}) ? {16'd0, cfg.max_level} : level;
      if (cfg.pwm_mode) begin
         pin_level = cfg.active_low ? cfg.max_level - clamped[15:0] : clamped[15:0];
      end else begin
         lit       = (clamped != 32'd0);
         pin_level = {15'd0, lit ^ cfg.active_low};
      end
   endfunction

   function automatic logic stop_blink();
      if (!running) return 1'b0;
      running = 1'b0;
      drive_pin(32'd0);
      return 1'b1;
   endfunction

   // one millisecond: at most one phase advance
   function automatic logic count_ms();
      if (!running) return 1'b0;
      if (elapsed < MS_CEILING) elapsed++;
      if (elapsed < duration_at(phase)) return 1'b0;
      elapsed = 32'd0;
      if (phase % 2 == 0) begin
         phase++;
         if (duration_at(phase) > 0) drive_pin(32'd0);
         return 1'b0;
      end
      phase++;
      if (phase >= 2 * pairs_in_use()) begin
         phase = 0;
         if (reps_target > 0) reps_done++;
      end
      if (reps_target > 0 && reps_done >= reps_target) return stop_blink();
      if (duration_at(phase) > 0) drive_pin({16'd0, cfg.blink_level});
      return 1'b0;
   endfunction

   function automatic rsp_type predict_pin(req_type r);
      rsp_type p;
      logic    ended;
      ended = 1'b0;
      case (r.mode)
         MODE_TICK: ended = count_ms();
         MODE_START: begin
            reps_target = r.repeat_count;
            drive_pin(duration_at(0) > 0 ? {16'd0, cfg.blink_level} : 32'd0);
            running     = 1'b1;
            reps_done   = 16'd0;
            phase       = 0;
            elapsed     = 32'd0;
         end
         MODE_STOP: ended = stop_blink();
         MODE_SET: begin
            if (!running) drive_pin(r.value);
         end
         MODE_WRITE: durations[r.entry_index] = r.value;
         default: ;
      endcase
      p.drive_level = pin_level;
      p.blinking    = running;
      p.finished    = ended;
      return p;
   endfunction

   function automatic void note_mismatch(string what, rsp_type want, rsp_type got);
      fail_count++;
      if (fail_count <= SHOWN_MAX)
         $display("%0t %s: expected level %h blinking %b finished %b, got %h %b %b",
                  $time, what, want.drive_level, want.blinking, want.finished,
                  got.drive_level, got.blinking, got.finished);
   endfunction

   always @(posedge clock) begin
      rsp_type want;
      if (reset) begin
         cfg         = '{1'b0, 1'b0, RESET_LEVEL, RESET_LEVEL, RESET_PAIRS};
         for (int i = 0; i < TABLE_DEPTH; i++) durations[i] = 32'd0;
         durations[0] = 32'(RESET_DURATION);
         durations[1] = 32'(RESET_DURATION);
         running      = 1'b0;
         phase        = 0;
         elapsed      = 32'd0;
         reps_done    = 16'd0;
         reps_target  = 16'd0;
         pin_level    = 16'd0;
         pin_states_due.delete();
         states_due   <= 0;
      end else begin
         // register writes land at this edge
         if (csr_write_en) begin
            case (csr_index)
               CSR_PWM_MODE:      cfg.pwm_mode      = csr_wdata[0];
               CSR_ACTIVE_LOW:    cfg.active_low    = csr_wdata[0];
               CSR_MAX_LEVEL:     cfg.max_level     = csr_wdata;
               CSR_BLINK_LEVEL:   cfg.blink_level   = csr_wdata;
               CSR_PATTERN_PAIRS: cfg.pattern_pairs = csr_wdata[2:0];
               default: ;
            endcase
         end
         // result transfer against the oldest expected pin state
         if (rsp_valid && !rsp_stall) begin
            if (pin_states_due.size() == 0) begin
               note_mismatch("response with nothing expected", '0, rsp_data);
            end else begin
               want = pin_states_due.pop_front();
               states_checked++;
               if (rsp_data.drive_level !== want.drive_level ||
                   rsp_data.blinking !== want.blinking ||
                   rsp_data.finished !== want.finished)
                  note_mismatch("pin state mismatch", want, rsp_data);
            end
         end
         // request transfer: advance the private sequencer
         if (req_valid && !req_stall) begin
            want = predict_pin(req_data);
            if (want.finished) blinks_ended++;
            pin_states_due.push_back(want);
         end
         states_due <= pin_states_due.size();
      end
   end

endmodule

// File: test/tb_led_blink_pattern_sequencer.sv
`timescale 1ns / 1ps

module tb_led_blink_pattern_sequencer;
   import lbp_pkg::*;

   localparam int         IDLE_LIMIT       = 2000;
   localparam int         PHASES           = 10;
   localparam int         PHASE_ITEMS      = 123;
   localparam int         LONG_HOLD        = 60;
   localparam int         SETTLE_CYCLES    = 4;
   localparam logic [2:0] MODE_SPARE_FIRST = MODE_WRITE + 3'd1;
   localparam logic [2:0] MODE_SPARE_LAST  = 3'd7;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid;
   logic        req_stall;
   req_type     req_data;
   logic        rsp_valid;
   logic        rsp_stall;
   rsp_type     rsp_data;
   logic        csr_write_en;
   logic [2:0]  csr_index;
   logic [15:0] csr_wdata;

   int fail_count, states_due, states_checked, blinks_ended;
   int idle_cycles;
   int items_sent, ticks_sent, starts_sent, settings_applied;
   int holds_asked, holds_done;
   bit quiet;

   always #1 clock = ~clock;

   led_blink_pattern_sequencer u_top (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_stall    (req_stall),
      .req_data     (req_data),
      .rsp_valid    (rsp_valid),
      .rsp_stall    (rsp_stall),
      .rsp_data     (rsp_data),
      .csr_write_en (csr_write_en),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata)
   );

   blink_checker u_checker (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_data       (req_data),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_data       (rsp_data),
      .csr_write_en   (csr_write_en),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata),
      .fail_count     (fail_count),
      .states_due     (states_due),
      .states_checked (states_checked),
      .blinks_ended   (blinks_ended)
   );

   // watchdog on cycles with no transfer on either channel
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
         $display("watchdog: no transfer for %0d cycles", IDLE_LIMIT);
         $display("tb_led_blink_pattern_sequencer NOT OK");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   // receiver: random stall bursts, long hold-offs on request, none when quiet
   initial begin
      rsp_stall = 1'b0;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         if (holds_done < holds_asked) begin
            rsp_stall <= 1'b1;
            repeat (LONG_HOLD) @(posedge clock);
            holds_done++;
            rsp_stall <= 1'b0;
            @(posedge clock);
         end else if (!quiet && $urandom_range(0, 7) == 0) begin
            rsp_stall <= 1'b1;
            repeat ($urandom_range(1, 12)) @(posedge clock);
            rsp_stall <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge clock);
         end else begin
            rsp_stall <= 1'b0;
            @(posedge clock);
         end
      end
   end

   function automatic req_type item(logic [2:0] mode, logic [15:0] count,
                                    logic [31:0] value, logic [2:0] idx);
      req_type r;
      r.mode         = mode;
      r.repeat_count = count;
      r.value        = value;
      r.entry_index  = idx;
      return r;
   endfunction

   // one request transfer, then maybe a sender gap
   task automatic offer(req_type r);
      req_valid <= 1'b1;
      req_data  <= r;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      items_sent++;
      if (r.mode == MODE_TICK) ticks_sent++;
      if (r.mode == MODE_START) starts_sent++;
      if (!quiet && $urandom_range(0, 9) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 12)) @(posedge clock);
      end
   endtask

   // ticks with random content in the ignored fields
   task automatic tick_burst(int n);
      repeat (n) offer(item(MODE_TICK, 16'($urandom), $urandom, 3'($urandom)));
   endtask

   // sender pauses until every pending transfer has its response
   task automatic settle();
      req_valid <= 1'b0;
      @(posedge clock);
      while (states_due != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic apply_settings(cfg_type c);
      csr_write_en <= 1'b1;
      csr_index    <= CSR_PWM_MODE;
      csr_wdata    <= {15'd0, c.pwm_mode};
      @(posedge clock);
      csr_index    <= CSR_ACTIVE_LOW;
      csr_wdata    <= {15'd0, c.active_low};
      @(posedge clock);
      csr_index    <= CSR_MAX_LEVEL;
      csr_wdata    <= c.max_level;
      @(posedge clock);
      csr_index    <= CSR_BLINK_LEVEL;
      csr_wdata    <= c.blink_level;
      @(posedge clock);
      csr_index    <= CSR_PATTERN_PAIRS;
      csr_wdata    <= {13'd0, c.pattern_pairs};
      @(posedge clock);
      csr_write_en <= 1'b0;
      settings_applied++;
   endtask

   initial begin
      cfg_type s;
      int      k;
      int      phase_end;
      req_valid    = 1'b0;
      req_data     = '0;
      csr_write_en = 1'b0;
      csr_index    = CSR_PWM_MODE;
      csr_wdata    = 16'd0;
      quiet        = 1'b0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: clamping, idle stop, table extremes, counted and endless blinks
      offer(item(MODE_SET, 16'd0, 32'hFFFF_FFFF, 3'd0));
      offer(item(MODE_SET, 16'hFFFF, 32'd0, 3'd7));
      offer(item(MODE_STOP, 16'd0, 32'd0, 3'd0));
      offer(item(MODE_WRITE, 16'd0, 32'hFFFF_FFFF, 3'd7));
      offer(item(MODE_WRITE, 16'd0, 32'd1, 3'd0));
      offer(item(MODE_WRITE, 16'd0, 32'd0, 3'd1));
      offer(item(MODE_START, 16'd2, 32'd0, 3'd0));
      tick_burst(4);
      offer(item(MODE_START, 16'd0, 32'd0, 3'd0));
      offer(item(MODE_SET, 16'd0, 32'd5, 3'd0));
      offer(item(MODE_START, 16'd1, 32'd0, 3'd0));
      offer(item(MODE_SPARE_FIRST, 16'hFFFF, 32'hFFFF_FFFF, 3'd7));
      offer(item(MODE_SPARE_LAST, 16'd0, 32'd0, 3'd0));
      offer(item(MODE_STOP, 16'd0, 32'd0, 3'd0));
      tick_burst(1);
      offer(item(MODE_WRITE, 16'd0, 32'd0, 3'd0));
      offer(item(MODE_START, 16'hFFFF, 32'd0, 3'd0));
      tick_burst(3);
      offer(item(MODE_STOP, 16'd0, 32'd0, 3'd0));
      offer(item(MODE_WRITE, 16'd0, 32'd3, 3'd7));
      settle();

      // random phases, each under its own register setting
      for (int ph = 0; ph < PHASES; ph++) begin
         case (ph)
            0: s = '{1'b1, 1'b0, 16'hFFFF, 16'hFFFF, 3'd4};
            1: s = '{1'b1, 1'b1, 16'd0, 16'd100, 3'd0};
            2: s = '{1'b0, 1'b1, 16'd1, 16'd0, 3'd7};
            3: s = '{1'b1, 1'b1, 16'hFFFF, 16'($urandom), 3'd2};
            4: s = '{1'b0, 1'b0, 16'd255, 16'd255, 3'd1};
            default: begin
               s.pwm_mode      = 1'($urandom);
               s.active_low    = 1'($urandom);
               s.max_level     = ($urandom_range(0, 3) == 0) ? 16'($urandom)
                                                             : 16'($urandom_range(1, 300));
               s.blink_level   = ($urandom_range(0, 3) == 0) ? 16'($urandom)
                                                             : 16'($urandom_range(0, 400));
               s.pattern_pairs = 3'($urandom);
            end
         endcase
         quiet = (ph == 4 || ph == PHASES - 1);
         apply_settings(s);
         if (ph == 3 || ph == 7) holds_asked++;
         phase_end = items_sent + PHASE_ITEMS;
         while (items_sent < phase_end) begin
            k = $urandom_range(0, 99);
            if (k < 65) begin
               // well-formed blink: reload a few durations, start, run ticks
               repeat ($urandom_range(0, 3))
                  offer(item(MODE_WRITE, 16'($urandom),
                             ($urandom_range(0, 23) == 0) ? $urandom : $urandom_range(0, 4),
                             3'($urandom)));
               if ($urandom_range(0, 3) != 0)
                  offer(item(MODE_START,
                             ($urandom_range(0, 7) == 0) ? 16'($urandom)
                                                         : 16'($urandom_range(0, 3)),
                             $urandom, 3'($urandom)));
               tick_burst($urandom_range(4, 30));
               if ($urandom_range(0, 5) == 0)
                  offer(item(MODE_SET, 16'($urandom), $urandom, 3'($urandom)));
               if ($urandom_range(0, 7) == 0)
                  offer(item(MODE_STOP, 16'($urandom), $urandom, 3'($urandom)));
            end else if (k < 80) begin
               tick_burst($urandom_range(1, 10));
            end else if (k < 92) begin
               offer(item(MODE_SET, 16'($urandom),
                          $urandom_range(0, 1) ? $urandom : $urandom_range(0, 400),
                          3'($urandom)));
            end else if (k < 96) begin
               offer(item(MODE_STOP, 16'($urandom), $urandom, 3'($urandom)));
            end else begin
               offer(item(3'($urandom_range(MODE_SPARE_FIRST, MODE_SPARE_LAST)),
                          16'($urandom), $urandom, 3'($urandom)));
            end
         end
         settle();
      end

      $display("run covered %0d requests (%0d ticks, %0d starts) under %0d register settings",
               items_sent, ticks_sent, starts_sent, settings_applied);
      $display("%0d responses compared, %0d blinks ended by count or stop",
               states_checked, blinks_ended);
      if (fail_count == 0 && states_due == 0) begin
         $display("tb_led_blink_pattern_sequencer OK");
      end else begin
         $display("tb_led_blink_pattern_sequencer NOT OK");
      end
      $finish;
   end

endmodule
